FILE: src/dtc_pkg.sv
package dtc_pkg;

  // default sizes
  localparam int NODE_COUNT_DEF    = 256;
  localparam int WALK_DEPTH_DEF    = 16;
  localparam int FEATURE_COUNT_DEF = 12;

  // fixed field widths
  localparam int VAL_W   = 48;
  localparam int SLOT_W  = 8;
  localparam int SEL_W   = 4;
  localparam int LABEL_W = 8;
  localparam int STAT_W  = 2;
  localparam int OP_W    = 2;

  // opcodes
  localparam logic [OP_W-1:0] OP_NODE     = 2'd0;
  localparam logic [OP_W-1:0] OP_FEAT     = 2'd1;
  localparam logic [OP_W-1:0] OP_CLASSIFY = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_FAIL  = 2'd2;

  // one node table entry
  typedef struct packed {
    logic               is_leaf;
    logic [SEL_W-1:0]   feature;
    logic               left_valid;
    logic [SLOT_W-1:0]  left;
    logic               right_valid;
    logic [SLOT_W-1:0]  right;
    logic [LABEL_W-1:0] label;
    logic [VAL_W-1:0]   threshold;
  } node_t;

  // controller -> datapath
  typedef struct packed {
    logic              wr_node;
    logic              wr_feat;
    logic              rd_root;
    logic              rd_next;
    logic              emit_valid;
    logic              emit_use_leaf;
    logic [STAT_W-1:0] emit_status;
  } dtc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic tree_present;
    logic is_leaf;
    logic child_ok;
  } dtc_stat_t;

endpackage

FILE: src/dtc_ctrl.sv
module dtc_ctrl #(
  parameter int WALK_DEPTH = dtc_pkg::WALK_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [dtc_pkg::OP_W-1:0]  opcode,
  input  dtc_pkg::dtc_stat_t        stat,
  output dtc_pkg::dtc_cmd_t         cmd,
  output logic                      busy
);

  localparam int DEPTH_W = $clog2(WALK_DEPTH + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic               state_r, state_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;

  // state and level counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      depth_r <= '0;
    end else begin
      state_r <= state_nxt;
      depth_r <= depth_nxt;
    end
  end

  assign busy = (state_r == ST_WALK);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    depth_nxt = depth_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (opcode)
            dtc_pkg::OP_NODE: cmd.wr_node = 1'b1;
            dtc_pkg::OP_FEAT: cmd.wr_feat = 1'b1;
            dtc_pkg::OP_CLASSIFY: begin
              if (stat.tree_present) begin
                cmd.rd_root = 1'b1;
                depth_nxt   = '0;
                state_nxt   = ST_WALK;
              end else begin
                cmd.emit_valid  = 1'b1;
                cmd.emit_status = dtc_pkg::STATUS_EMPTY;
              end
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        if (stat.is_leaf) begin
          cmd.emit_valid    = 1'b1;
          cmd.emit_use_leaf = 1'b1;
          cmd.emit_status   = dtc_pkg::STATUS_OK;
          state_nxt         = ST_IDLE;
        end else if (depth_r >= DEPTH_W'(WALK_DEPTH) || !stat.child_ok) begin
          cmd.emit_valid  = 1'b1;
          cmd.emit_status = dtc_pkg::STATUS_FAIL;
          state_nxt       = ST_IDLE;
        end else begin
          cmd.rd_next = 1'b1;
          depth_nxt   = depth_r + 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

FILE: src/dtc_dpath.sv
module dtc_dpath #(
  parameter int NODE_COUNT    = dtc_pkg::NODE_COUNT_DEF,
  parameter int FEATURE_COUNT = dtc_pkg::FEATURE_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dtc_pkg::dtc_cmd_t             cmd,
  output dtc_pkg::dtc_stat_t            stat,
  input  logic                          cfg_we,
  input  logic [dtc_pkg::LABEL_W-1:0]   cfg_data,
  input  logic [dtc_pkg::SLOT_W-1:0]    node_index,
  input  logic                          node_is_leaf,
  input  logic [dtc_pkg::SEL_W-1:0]     node_feature,
  input  logic [dtc_pkg::VAL_W-1:0]     node_threshold,
  input  logic                          node_left_valid,
  input  logic [dtc_pkg::SLOT_W-1:0]    node_left,
  input  logic                          node_right_valid,
  input  logic [dtc_pkg::SLOT_W-1:0]    node_right,
  input  logic [dtc_pkg::LABEL_W-1:0]   node_label,
  input  logic [dtc_pkg::SEL_W-1:0]     feature_slot,
  input  logic [dtc_pkg::VAL_W-1:0]     feature_value,
  output logic                          out_strobe,
  output logic [dtc_pkg::LABEL_W-1:0]   out_app_label,
  output logic [dtc_pkg::STAT_W-1:0]    out_status
);

  localparam int NODE_AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int FEAT_AW = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
  localparam int CMP_W   = NODE_AW + dtc_pkg::SLOT_W + 1;
  localparam int SCMP_W  = FEAT_AW + dtc_pkg::SEL_W + 1;

  dtc_pkg::node_t            mem [NODE_COUNT];
  dtc_pkg::node_t            rd_data_r;
  logic [dtc_pkg::VAL_W-1:0] feat_r [FEATURE_COUNT];
  logic                      tree_present_r;
  logic [dtc_pkg::LABEL_W-1:0] unknown_label_r;
  logic                      out_strobe_r;
  logic [dtc_pkg::LABEL_W-1:0] out_label_r;
  logic [dtc_pkg::STAT_W-1:0]  out_status_r;

  dtc_pkg::node_t            wr_entry;
  logic                      wr_in_range;
  logic [NODE_AW-1:0]        wr_addr;
  logic                      fw_in_range;
  logic [dtc_pkg::VAL_W-1:0] sel_value;
  logic                      go_left;
  logic                      child_valid;
  logic [dtc_pkg::SLOT_W-1:0] child_slot;
  logic                      child_in_range;
  logic [NODE_AW-1:0]        rd_addr;

  // node write decode
  assign wr_in_range = (CMP_W'(node_index) < CMP_W'(NODE_COUNT));
  assign wr_addr     = NODE_AW'(node_index);
  assign fw_in_range = (SCMP_W'(feature_slot) < SCMP_W'(FEATURE_COUNT));

  always_comb begin
    wr_entry.is_leaf     = node_is_leaf;
    wr_entry.feature     = node_feature;
    wr_entry.left_valid  = node_left_valid;
    wr_entry.left        = node_left;
    wr_entry.right_valid = node_right_valid;
    wr_entry.right       = node_right;
    wr_entry.label       = node_label;
    wr_entry.threshold   = node_threshold;
  end

  // branch decision on the node just read
  always_comb begin
    if (SCMP_W'(rd_data_r.feature) < SCMP_W'(FEATURE_COUNT)) begin
      sel_value = feat_r[FEAT_AW'(rd_data_r.feature)];
    end else begin
      sel_value = '0;
    end
    go_left = (sel_value <= rd_data_r.threshold);
    if (go_left) begin
      child_valid = rd_data_r.left_valid;
      child_slot  = rd_data_r.left;
    end else begin
      child_valid = rd_data_r.right_valid;
      child_slot  = rd_data_r.right;
    end
  end

  assign child_in_range = (CMP_W'(child_slot) < CMP_W'(NODE_COUNT));
  assign rd_addr        = cmd.rd_root ? '0 : NODE_AW'(child_slot);

  assign stat.tree_present = tree_present_r;
  assign stat.is_leaf      = rd_data_r.is_leaf;
  assign stat.child_ok     = child_valid && child_in_range;

  // node table, one write and one registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_node && wr_in_range) begin
      mem[wr_addr] <= wr_entry;
    end
    if (cmd.rd_root || cmd.rd_next) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // feature file, tree flag, label register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FEATURE_COUNT; i++) begin
        feat_r[i] <= '0;
      end
      tree_present_r  <= 1'b0;
      unknown_label_r <= '0;
    end else begin
      if (cmd.wr_feat && fw_in_range) begin
        feat_r[FEAT_AW'(feature_slot)] <= feature_value;
      end
      if (cmd.wr_node && node_index == '0) begin
        tree_present_r <= 1'b1;
      end
      if (cfg_we) begin
        unknown_label_r <= cfg_data;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.emit_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_valid) begin
      out_label_r  <= cmd.emit_use_leaf ? rd_data_r.label : unknown_label_r;
      out_status_r <= cmd.emit_status;
    end
  end

  assign out_strobe    = out_strobe_r;
  assign out_app_label = out_label_r;
  assign out_status    = out_status_r;

endmodule

FILE: src/decision_tree_classifier.sv
// Write items (node or feature) give no result and busy stays low.
// Classify reads one tree level per cycle from the node table (1 to WALK_DEPTH+1
// levels), result strobe the cycle after the last level; empty tree: strobe next cycle.
// Next item accepted in the cycle the result is shown, none while a walk is busy.
// The one node table read per level sets the rate; the receiver cannot stall.
// Synchronous active-low reset clears features, tree flag, label register and control.
module decision_tree_classifier #(
  parameter int NODE_COUNT    = dtc_pkg::NODE_COUNT_DEF,
  parameter int WALK_DEPTH    = dtc_pkg::WALK_DEPTH_DEF,
  parameter int FEATURE_COUNT = dtc_pkg::FEATURE_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [dtc_pkg::OP_W-1:0]      in_opcode,
  input  logic [dtc_pkg::SLOT_W-1:0]    in_node_index,
  input  logic                          in_node_is_leaf,
  input  logic [dtc_pkg::SEL_W-1:0]     in_node_feature,
  input  logic [dtc_pkg::VAL_W-1:0]     in_node_threshold,
  input  logic                          in_node_left_valid,
  input  logic [dtc_pkg::SLOT_W-1:0]    in_node_left,
  input  logic                          in_node_right_valid,
  input  logic [dtc_pkg::SLOT_W-1:0]    in_node_right,
  input  logic [dtc_pkg::LABEL_W-1:0]   in_node_label,
  input  logic [dtc_pkg::SEL_W-1:0]     in_feature_slot,
  input  logic [dtc_pkg::VAL_W-1:0]     in_feature_value,
  output logic                          out_strobe,
  output logic [dtc_pkg::LABEL_W-1:0]   out_app_label,
  output logic [dtc_pkg::STAT_W-1:0]    out_status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dtc_pkg::LABEL_W-1:0]   cfg_data
);

  dtc_pkg::dtc_cmd_t  cmd;
  dtc_pkg::dtc_stat_t stat;

  // config register always takes a word
  assign cfg_ready = 1'b1;

  dtc_ctrl #(
    .WALK_DEPTH (WALK_DEPTH)
  ) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .opcode (in_opcode),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  dtc_dpath #(
    .NODE_COUNT    (NODE_COUNT),
    .FEATURE_COUNT (FEATURE_COUNT)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_data         (cfg_data),
    .node_index       (in_node_index),
    .node_is_leaf     (in_node_is_leaf),
    .node_feature     (in_node_feature),
    .node_threshold   (in_node_threshold),
    .node_left_valid  (in_node_left_valid),
    .node_left        (in_node_left),
    .node_right_valid (in_node_right_valid),
    .node_right       (in_node_right),
    .node_label       (in_node_label),
    .feature_slot     (in_feature_slot),
    .feature_value    (in_feature_value),
    .out_strobe       (out_strobe),
    .out_app_label    (out_app_label),
    .out_status       (out_status)
  );

  // a walk that ends always shows its result in the same cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(busy) |-> out_strobe)
    else $error("walk ended without a result");

  // a classify either starts a walk or answers right away
  assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_opcode == dtc_pkg::OP_CLASSIFY |=> busy || out_strobe)
    else $error("classify item dropped");

  // results only come while idle, never with an unused status
  assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy && (out_status == dtc_pkg::STATUS_OK ||
                             out_status == dtc_pkg::STATUS_EMPTY ||
                             out_status == dtc_pkg::STATUS_FAIL))
    else $error("bad result timing or status");

  // a successful result only follows a walk
  assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_status == dtc_pkg::STATUS_OK |-> $past(busy))
    else $error("ok result without a walk");

endmodule
